@@ src/prx_pkg.sv @@
// Shared constants, codes and types of the packet receive ring.
// Every other file of the block but prx_ram imports this package.
package prx_pkg;

  localparam int PACKET_BYTES = 64;
  localparam int RING_SLOTS = 2 * PACKET_BYTES;
  localparam int IDX_W = $clog2(RING_SLOTS);
  localparam int FILL_W = IDX_W + 1;
  localparam int OP_W = 2;
  localparam int BYTE_W = 8;
  localparam int LEVEL_W = 7;

  localparam logic [OP_W-1:0] OP_PACKET = 2'd0;
  localparam logic [OP_W-1:0] OP_READ = 2'd1;
  localparam logic [OP_W-1:0] OP_RESET = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [FILL_W-1:0] fill_t;

  typedef struct packed {
    logic take;
    logic load_direct;
    logic load_pop;
  } cmd_t;

  typedef struct packed {
    logic pop;
  } status_t;

endpackage

@@ src/prx_request_if.sv @@
// Request channel of the packet receive ring: valid, ready and one input item.
// Depends on prx_pkg.
interface prx_request_if;
  import prx_pkg::*;

  logic valid;
  logic ready;
  logic [OP_W-1:0] operation;
  logic byte_present;
  logic [BYTE_W-1:0] packet_byte;
  logic end_of_packet;

  modport source(output valid, operation, byte_present, packet_byte, end_of_packet,
                 input ready);
  modport sink(input valid, operation, byte_present, packet_byte, end_of_packet,
               output ready);
endinterface

@@ src/prx_result_if.sv @@
// Result channel of the packet receive ring: valid, ready and one result item.
// Depends on prx_pkg.
interface prx_result_if;
  import prx_pkg::*;

  logic valid;
  logic ready;
  logic [BYTE_W-1:0] read_byte;
  logic read_valid;
  logic byte_dropped;
  logic endpoint_arm;
  logic receive_enabled;
  logic [LEVEL_W-1:0] fill_level;

  modport source(output valid, read_byte, read_valid, byte_dropped, endpoint_arm,
                 receive_enabled, fill_level, input ready);
  modport sink(input valid, read_byte, read_valid, byte_dropped, endpoint_arm,
               receive_enabled, fill_level, output ready);
endinterface

@@ src/prx_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package needed.
module prx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

@@ src/prx_ctrl.sv @@
// Controller of the packet receive ring: handshakes, fetch sequencing and
// the result valid flag. Depends on prx_pkg.
module prx_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  prx_pkg::status_t status,
  output prx_pkg::cmd_t    cmd
);
  import prx_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_FETCH = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;

  assign in_ready = (state == ST_IDLE) && (!out_valid || out_ready);
  assign cmd.take = in_valid && in_ready;
  assign cmd.load_direct = cmd.take && !status.pop;
  assign cmd.load_pop = (state == ST_FETCH);

  always_comb begin
    state_next = state;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        if (cmd.load_direct) begin
          out_valid_next = 1'b1;
        end else if (cmd.take) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        out_valid_next = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef ASSERT_OFF
  a_pop_follows_take: assert property (@(posedge clk) disable iff (rst)
    cmd.load_pop |-> $past(cmd.take && status.pop))
    else $error("pop load without a preceding read transfer");

  a_direct_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_direct |=> out_valid)
    else $error("result not presented after a direct load");

  a_fetch_slot_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && status.pop) |=> !out_valid)
    else $error("result register occupied during a fetch");

  a_no_take_in_fetch: assert property (@(posedge clk) disable iff (rst)
    cmd.load_pop |-> !cmd.take)
    else $error("request taken while a fetch is in flight");
`endif
endmodule

@@ src/prx_dp.sv @@
// Datapath of the packet receive ring: indices, flow-control flag, ring RAM
// and the result register. Depends on prx_pkg and prx_ram.
module prx_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  prx_pkg::cmd_t                 cmd,
  output prx_pkg::status_t              status,
  input  logic [prx_pkg::OP_W-1:0]      operation,
  input  logic                          byte_present,
  input  logic [prx_pkg::BYTE_W-1:0]    packet_byte,
  input  logic                          end_of_packet,
  output logic [prx_pkg::BYTE_W-1:0]    read_byte,
  output logic                          read_valid,
  output logic                          byte_dropped,
  output logic                          endpoint_arm,
  output logic                          receive_enabled,
  output logic [prx_pkg::LEVEL_W-1:0]   fill_level
);
  import prx_pkg::*;

  localparam fill_t SLOTS_F = FILL_W'(RING_SLOTS);
  localparam fill_t MAX_FILL = FILL_W'(RING_SLOTS - 1);
  localparam fill_t PACKET_F = FILL_W'(PACKET_BYTES);
  localparam idx_t LAST_IDX = IDX_W'(RING_SLOTS - 1);

  idx_t wr_idx;
  idx_t wr_idx_next;
  idx_t rd_idx;
  idx_t rd_idx_next;
  logic rx_flag;
  logic rx_flag_next;
  logic pend_arm;
  logic arm_next;
  logic drop_next;
  logic wr_en;
  logic rd_en;
  logic [BYTE_W-1:0] ram_q;
  fill_t fill_now;
  fill_t fill_after;
  fill_t free_after;

  assign fill_now = FILL_W'(wr_idx) + ((wr_idx < rd_idx) ? SLOTS_F : '0) - FILL_W'(rd_idx);
  assign status.pop = (operation == OP_READ) && (rd_idx != wr_idx);
  assign rd_en = cmd.take && status.pop;

  always_comb begin
    wr_idx_next = wr_idx;
    rd_idx_next = rd_idx;
    rx_flag_next = rx_flag;
    arm_next = 1'b0;
    drop_next = 1'b0;
    wr_en = 1'b0;
    fill_after = fill_now;
    free_after = MAX_FILL - fill_after;
    case (operation)
      OP_PACKET: begin
        if (byte_present) begin
          if (fill_now == MAX_FILL) begin
            drop_next = 1'b1;
          end else begin
            wr_en = cmd.take;
            wr_idx_next = (wr_idx == LAST_IDX) ? '0 : wr_idx + 1'b1;
            fill_after = fill_now + 1'b1;
          end
        end
        free_after = MAX_FILL - fill_after;
        if (end_of_packet) begin
          if (free_after >= PACKET_F) begin
            arm_next = 1'b1;
          end else begin
            rx_flag_next = 1'b0;
          end
        end
      end
      OP_READ: begin
        if (status.pop) begin
          rd_idx_next = (rd_idx == LAST_IDX) ? '0 : rd_idx + 1'b1;
          fill_after = fill_now - 1'b1;
          free_after = MAX_FILL - fill_after;
          if (!rx_flag && (free_after >= PACKET_F)) begin
            arm_next = 1'b1;
            rx_flag_next = 1'b1;
          end
        end
      end
      OP_RESET: begin
        wr_idx_next = '0;
        rd_idx_next = '0;
        arm_next = 1'b1;
        fill_after = '0;
      end
      default: begin
      end
    endcase
  end

  prx_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(RING_SLOTS)
  ) u_ring (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_idx),
    .wr_data(packet_byte),
    .rd_en  (rd_en),
    .rd_addr(rd_idx),
    .rd_data(ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      rx_flag <= 1'b0;
    end else if (cmd.take) begin
      wr_idx <= wr_idx_next;
      rd_idx <= rd_idx_next;
      rx_flag <= rx_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pend_arm <= arm_next;
    end
    if (cmd.load_direct) begin
      read_byte <= '0;
      read_valid <= 1'b0;
      byte_dropped <= drop_next;
      endpoint_arm <= arm_next;
      receive_enabled <= rx_flag_next;
      fill_level <= LEVEL_W'(fill_after);
    end else if (cmd.load_pop) begin
      read_byte <= ram_q;
      read_valid <= 1'b1;
      byte_dropped <= 1'b0;
      endpoint_arm <= pend_arm;
      receive_enabled <= rx_flag;
      fill_level <= LEVEL_W'(fill_now);
    end
  end

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_now <= MAX_FILL)
    else $error("ring fill exceeds its capacity");

  a_drop_when_full: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && drop_next) |=> (fill_now == MAX_FILL))
    else $error("ring not full after a dropped byte");

  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && (operation == OP_RESET)) |=> ((wr_idx == '0) && (rd_idx == '0)))
    else $error("ring indices not cleared by a reset item");
`endif
endmodule

@@ src/packet_rx_ring_with_flow_control.sv @@
// Packet receive ring with flow control: bridges a packet endpoint to a byte
// reader through a ring RAM of 2*PACKET_BYTES slots, one of which always stays
// empty. Packet items, reset items and reads of an empty ring load the result
// register directly and can follow back to back; a read that pops a byte goes
// through a fetch state for the registered RAM read port; no item is taken
// in that state. Every item gives exactly one result, held in an output
// register; the next item is taken only in a cycle in which that register
// is empty or its result is being transferred. No clearing pass runs after reset.
module packet_rx_ring_with_flow_control (
  input logic          clk,
  input logic          rst,
  prx_request_if.sink  request,
  prx_result_if.source result
);
  import prx_pkg::*;

  cmd_t cmd;
  status_t status;

  prx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .in_ready (request.ready),
    .out_valid(result.valid),
    .out_ready(result.ready),
    .status   (status),
    .cmd      (cmd)
  );

  prx_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .operation      (request.operation),
    .byte_present   (request.byte_present),
    .packet_byte    (request.packet_byte),
    .end_of_packet  (request.end_of_packet),
    .read_byte      (result.read_byte),
    .read_valid     (result.read_valid),
    .byte_dropped   (result.byte_dropped),
    .endpoint_arm   (result.endpoint_arm),
    .receive_enabled(result.receive_enabled),
    .fill_level     (result.fill_level)
  );
endmodule
